[rtl/camera_project_with_distortion_assert.svh]
// Assertion macros used by the checker file of the camera projection block.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef CAMERA_PROJECT_WITH_DISTORTION_ASSERT_SVH
`define CAMERA_PROJECT_WITH_DISTORTION_ASSERT_SVH

// Condition that must hold at every clock edge outside reset
`define CPD_ASSERT_NOW(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent
`define CPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/cpd_pkg.sv]
// Package for the camera projection block: stage counts, register codes,
// coefficient struct and the 32-bit saturation helper. No dependencies.
`default_nettype none

package cpd_pkg;

	// Quotient bits of x*2^16 / z, one per divider stage
	localparam int unsigned DIV_BITS    = 48;
	// Divider: operand stage, DIV_BITS steps, sign and clamp stage
	localparam int unsigned DIV_STAGES  = DIV_BITS + 2;
	// Distortion and projection stages, the last one is the output register
	localparam int unsigned DIST_STAGES = 13;
	localparam int unsigned NUM_STAGES  = DIV_STAGES + DIST_STAGES;

	// 1.0 in signed Q8.24
	localparam logic signed [31:0] ONE_Q24 = 32'sd16777216;

	typedef enum logic [2:0] {
		REG_FOCAL_X    = 3'd0,
		REG_FOCAL_Y    = 3'd1,
		REG_CENTER_X   = 3'd2,
		REG_CENTER_Y   = 3'd3,
		REG_RADIAL_K1  = 3'd4,
		REG_RADIAL_K2  = 3'd5,
		REG_RADIAL_K3  = 3'd6,
		REG_TANGENTIAL = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic        [31:0] focal_x;
		logic        [31:0] focal_y;
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] k1;
		logic signed [31:0] k2;
		logic signed [31:0] k3;
		logic signed [31:0] t1;
		logic signed [31:0] t2;
	} coef_t;

	typedef struct packed {
		logic               ov;
		logic signed [31:0] val;
	} sat_t;

	// Clamp a wide signed value to the 32-bit signed range, flag any clamp
	function automatic sat_t sat32(input logic signed [71:0] v);
		sat_t r;
		if (v > 72'sd2147483647) begin
			r.ov  = 1'b1;
			r.val = 32'sh7fffffff;
		end else if (v < -72'sd2147483648) begin
			r.ov  = 1'b1;
			r.val = 32'sh80000000;
		end else begin
			r.ov  = 1'b0;
			r.val = v[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/camera_project_with_distortion.sv]
// Top level of the camera projection block: configuration registers, stage
// valid chain, divider and distortion pipelines. Depends on cpd_pkg,
// cpd_div and cpd_dist.
`default_nettype none

// Projects one camera-frame point (Q16.16) to a distorted pixel (Q16.16) per
// clock when nothing stalls. A point taken on the point channel leaves as a
// pixel word; the depth is dominated by the 48-step divider that forms x/z
// and y/z, followed by 13 distortion and projection stages, the last of
// which is the output register. Each stage holds its word only while the
// stage after it is full and stalled, so bubbles collapse and the point
// channel stalls only when every stage holds a word. Zero depth gives zero
// pixels with zero_depth set and overflowed clear; else any clamp along
// the way sets overflowed. Configuration writes are always accepted and
// must be made while the pipeline is empty.
module camera_project_with_distortion (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// point channel
	input  wire logic               point_valid,
	output logic                    point_stall,
	input  wire logic signed [31:0] point_x,
	input  wire logic signed [31:0] point_y,
	input  wire logic signed [31:0] point_z,
	// pixel channel
	output logic                    pixel_valid,
	input  wire logic               pixel_stall,
	output logic signed [31:0]      pixel_u,
	output logic signed [31:0]      pixel_v,
	output logic                    zero_depth,
	output logic                    overflowed,
	// configuration write channel
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [63:0]        cfg_data
);

	localparam int unsigned NS = cpd_pkg::NUM_STAGES;

	// Configuration registers
	logic [31:0] focal_x_q, focal_y_q, center_x_q, center_y_q;
	logic [31:0] k1_q, k2_q, k3_q;
	logic [63:0] tang_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= 32'd65536;
			focal_y_q  <= 32'd65536;
			center_x_q <= '0;
			center_y_q <= '0;
			k1_q       <= '0;
			k2_q       <= '0;
			k3_q       <= '0;
			tang_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cpd_pkg::cfg_reg_t'(cfg_index))
				cpd_pkg::REG_FOCAL_X:    focal_x_q  <= cfg_data[31:0];
				cpd_pkg::REG_FOCAL_Y:    focal_y_q  <= cfg_data[31:0];
				cpd_pkg::REG_CENTER_X:   center_x_q <= cfg_data[31:0];
				cpd_pkg::REG_CENTER_Y:   center_y_q <= cfg_data[31:0];
				cpd_pkg::REG_RADIAL_K1:  k1_q       <= cfg_data[31:0];
				cpd_pkg::REG_RADIAL_K2:  k2_q       <= cfg_data[31:0];
				cpd_pkg::REG_RADIAL_K3:  k3_q       <= cfg_data[31:0];
				cpd_pkg::REG_TANGENTIAL: tang_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	cpd_pkg::coef_t coef;

	assign coef.focal_x  = focal_x_q;
	assign coef.focal_y  = focal_y_q;
	assign coef.center_x = center_x_q;
	assign coef.center_y = center_y_q;
	assign coef.k1       = k1_q;
	assign coef.k2       = k2_q;
	assign coef.k3       = k3_q;
	assign coef.t1       = tang_q[31:0];
	assign coef.t2       = tang_q[63:32];

	// Stage enables: a stage advances when empty or when the next one advances
	logic [NS-1:0] vld_q;
	logic [NS-1:0] en;

	assign en[NS-1] = !vld_q[NS-1] || !pixel_stall;
	for (genvar i = 0; i < NS - 1; i++) begin : g_en
		assign en[i] = !vld_q[i] || en[i+1];
	end

	assign point_stall = !en[0];
	assign pixel_valid = vld_q[NS-1];

	// Advance valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= point_valid;
			end
			for (int i = 1; i < NS; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	logic signed [31:0] u, v;
	logic               div_ov, div_zero;

	cpd_div u_div (
		.clk     (clk),
		.en      (en[cpd_pkg::DIV_STAGES-1:0]),
		.point_x (point_x),
		.point_y (point_y),
		.point_z (point_z),
		.u       (u),
		.v       (v),
		.ov      (div_ov),
		.zero    (div_zero)
	);

	cpd_dist u_dist (
		.clk        (clk),
		.en         (en[NS-1:cpd_pkg::DIV_STAGES]),
		.coef       (coef),
		.u_in       (u),
		.v_in       (v),
		.ov_in      (div_ov),
		.zero_in    (div_zero),
		.pixel_u    (pixel_u),
		.pixel_v    (pixel_v),
		.zero_depth (zero_depth),
		.overflowed (overflowed)
	);

endmodule

`default_nettype wire

[rtl/cpd_div.sv]
// Pipelined restoring divider: u = x*2^16/z and v = y*2^16/z, truncated
// toward zero and clamped to Q16.16. Depends on cpd_pkg.
`default_nettype none

module cpd_div (
	input  wire logic                                clk,
	input  wire logic [cpd_pkg::DIV_STAGES-1:0]      en,
	input  wire logic signed [31:0]                  point_x,
	input  wire logic signed [31:0]                  point_y,
	input  wire logic signed [31:0]                  point_z,
	output logic signed [31:0]                       u,
	output logic signed [31:0]                       v,
	output logic                                     ov,
	output logic                                     zero
);

	localparam int unsigned NB = cpd_pkg::DIV_BITS;

	// Per-step state, index 0 is the operand stage
	logic [NB-1:0] nx_s  [0:NB];
	logic [NB-1:0] ny_s  [0:NB];
	logic [NB-1:0] qx_s  [0:NB];
	logic [NB-1:0] qy_s  [0:NB];
	logic [31:0]   rx_s  [0:NB];
	logic [31:0]   ry_s  [0:NB];
	logic [31:0]   den_s [0:NB];
	logic          negx_s[0:NB];
	logic          negy_s[0:NB];
	logic          zero_s[0:NB];

	logic [31:0] abs_x, abs_y, abs_z;

	// Magnitudes of the operands
	assign abs_x = point_x[31] ? (~point_x + 32'd1) : point_x;
	assign abs_y = point_y[31] ? (~point_y + 32'd1) : point_y;
	assign abs_z = point_z[31] ? (~point_z + 32'd1) : point_z;

	// Load scaled dividends and divisor magnitude
	always_ff @(posedge clk) begin
		if (en[0]) begin
			nx_s[0]   <= {abs_x, 16'd0};
			ny_s[0]   <= {abs_y, 16'd0};
			qx_s[0]   <= '0;
			qy_s[0]   <= '0;
			rx_s[0]   <= '0;
			ry_s[0]   <= '0;
			den_s[0]  <= abs_z;
			negx_s[0] <= point_x[31] ^ point_z[31];
			negy_s[0] <= point_y[31] ^ point_z[31];
			zero_s[0] <= (point_z == 32'sd0);
		end
	end

	// One quotient bit per stage for each lane
	for (genvar i = 1; i <= NB; i++) begin : g_step
		logic [32:0] trial_x, trial_y, diff_x, diff_y;

		assign trial_x = {rx_s[i-1], nx_s[i-1][NB-1]};
		assign trial_y = {ry_s[i-1], ny_s[i-1][NB-1]};
		assign diff_x  = trial_x - {1'b0, den_s[i-1]};
		assign diff_y  = trial_y - {1'b0, den_s[i-1]};

		always_ff @(posedge clk) begin
			if (en[i]) begin
				nx_s[i]   <= {nx_s[i-1][NB-2:0], 1'b0};
				ny_s[i]   <= {ny_s[i-1][NB-2:0], 1'b0};
				qx_s[i]   <= {qx_s[i-1][NB-2:0], ~diff_x[32]};
				qy_s[i]   <= {qy_s[i-1][NB-2:0], ~diff_y[32]};
				rx_s[i]   <= diff_x[32] ? trial_x[31:0] : diff_x[31:0];
				ry_s[i]   <= diff_y[32] ? trial_y[31:0] : diff_y[31:0];
				den_s[i]  <= den_s[i-1];
				negx_s[i] <= negx_s[i-1];
				negy_s[i] <= negy_s[i-1];
				zero_s[i] <= zero_s[i-1];
			end
		end
	end

	logic signed [NB:0] sq_x, sq_y;
	cpd_pkg::sat_t      sat_x, sat_y;

	// Apply quotient sign and clamp
	assign sq_x  = negx_s[NB] ? -signed'({1'b0, qx_s[NB]}) : signed'({1'b0, qx_s[NB]});
	assign sq_y  = negy_s[NB] ? -signed'({1'b0, qy_s[NB]}) : signed'({1'b0, qy_s[NB]});
	assign sat_x = cpd_pkg::sat32(72'(sq_x));
	assign sat_y = cpd_pkg::sat32(72'(sq_y));

	always_ff @(posedge clk) begin
		if (en[NB+1]) begin
			u    <= sat_x.val;
			v    <= sat_y.val;
			ov   <= (sat_x.ov | sat_y.ov) & ~zero_s[NB];
			zero <= zero_s[NB];
		end
	end

endmodule

`default_nettype wire

[rtl/cpd_dist.sv]
// Distortion and projection pipeline: radial and tangential terms, focal
// scaling and center offset, with the output register. Depends on cpd_pkg.
`default_nettype none

module cpd_dist (
	input  wire logic                                clk,
	input  wire logic [cpd_pkg::DIST_STAGES-1:0]     en,
	input  wire cpd_pkg::coef_t                      coef,
	input  wire logic signed [31:0]                  u_in,
	input  wire logic signed [31:0]                  v_in,
	input  wire logic                                ov_in,
	input  wire logic                                zero_in,
	output logic signed [31:0]                       pixel_u,
	output logic signed [31:0]                       pixel_v,
	output logic                                     zero_depth,
	output logic                                     overflowed
);

	// Flags carried with every stage
	logic [cpd_pkg::DIST_STAGES-1:1] zf_s;
	logic                            ovf_s [1:cpd_pkg::DIST_STAGES-1];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			zf_s[1]  <= zero_in;
		end
		for (int i = 2; i < cpd_pkg::DIST_STAGES; i++) begin
			if (en[i-1]) begin
				zf_s[i] <= zf_s[i-1];
			end
		end
	end

	// Stage 1: squares and cross product
	logic signed [63:0] m_uu_s1, m_vv_s1, m_uv_s1;
	logic signed [31:0] u_s1, v_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			m_uu_s1  <= u_in * u_in;
			m_vv_s1  <= v_in * v_in;
			m_uv_s1  <= u_in * v_in;
			u_s1     <= u_in;
			v_s1     <= v_in;
			ovf_s[1] <= ov_in;
		end
	end

	// Stage 2: scale and clamp products
	cpd_pkg::sat_t      sat_uu, sat_vv, sat_uv;
	logic signed [31:0] uu_s2, vv_s2, uv_s2, u_s2, v_s2;

	assign sat_uu = cpd_pkg::sat32(72'(m_uu_s1 >>> 16));
	assign sat_vv = cpd_pkg::sat32(72'(m_vv_s1 >>> 16));
	assign sat_uv = cpd_pkg::sat32(72'(m_uv_s1 >>> 16));

	always_ff @(posedge clk) begin
		if (en[1]) begin
			uu_s2    <= sat_uu.val;
			vv_s2    <= sat_vv.val;
			uv_s2    <= sat_uv.val;
			u_s2     <= u_s1;
			v_s2     <= v_s1;
			ovf_s[2] <= ovf_s[1] | sat_uu.ov | sat_vv.ov | sat_uv.ov;
		end
	end

	// Stage 3: radius squared and doubled cross product
	cpd_pkg::sat_t      sat_r, sat_2uv;
	logic signed [31:0] r_s3, two_uv_s3, uu_s3, vv_s3, u_s3, v_s3;

	assign sat_r   = cpd_pkg::sat32(72'(uu_s2) + 72'(vv_s2));
	assign sat_2uv = cpd_pkg::sat32(72'(uv_s2) + 72'(uv_s2));

	always_ff @(posedge clk) begin
		if (en[2]) begin
			r_s3      <= sat_r.val;
			two_uv_s3 <= sat_2uv.val;
			uu_s3     <= uu_s2;
			vv_s3     <= vv_s2;
			u_s3      <= u_s2;
			v_s3      <= v_s2;
			ovf_s[3]  <= ovf_s[2] | sat_r.ov | sat_2uv.ov;
		end
	end

	// Stage 4: r^2 product and tangential bases
	cpd_pkg::sat_t      sat_bx, sat_by;
	logic signed [63:0] m_r2_s4;
	logic signed [31:0] bx_s4, by_s4, r_s4, two_uv_s4, u_s4, v_s4;

	assign sat_bx = cpd_pkg::sat32(72'(r_s3) + 72'(uu_s3) + 72'(uu_s3));
	assign sat_by = cpd_pkg::sat32(72'(r_s3) + 72'(vv_s3) + 72'(vv_s3));

	always_ff @(posedge clk) begin
		if (en[3]) begin
			m_r2_s4   <= r_s3 * r_s3;
			bx_s4     <= sat_bx.val;
			by_s4     <= sat_by.val;
			r_s4      <= r_s3;
			two_uv_s4 <= two_uv_s3;
			u_s4      <= u_s3;
			v_s4      <= v_s3;
			ovf_s[4]  <= ovf_s[3] | sat_bx.ov | sat_by.ov;
		end
	end

	// Stage 5: r^2, tangential products, k1 term
	cpd_pkg::sat_t      sat_r2;
	logic signed [63:0] m_a_s5, m_b_s5, m_c_s5, m_d_s5, m_k1_s5;
	logic signed [31:0] r2_s5, r_s5, u_s5, v_s5;

	assign sat_r2 = cpd_pkg::sat32(72'(m_r2_s4 >>> 16));

	always_ff @(posedge clk) begin
		if (en[4]) begin
			r2_s5    <= sat_r2.val;
			m_a_s5   <= two_uv_s4 * coef.t1;
			m_b_s5   <= bx_s4 * coef.t2;
			m_c_s5   <= two_uv_s4 * coef.t2;
			m_d_s5   <= by_s4 * coef.t1;
			m_k1_s5  <= coef.k1 * r_s4;
			r_s5     <= r_s4;
			u_s5     <= u_s4;
			v_s5     <= v_s4;
			ovf_s[5] <= ovf_s[4] | sat_r2.ov;
		end
	end

	// Stage 6: r^3 and k2 products, tangential sums
	cpd_pkg::sat_t      sat_tx, sat_ty;
	logic signed [63:0] m_r3_s6, m_k2_s6;
	logic signed [47:0] fk1_s6;
	logic signed [31:0] tx_s6, ty_s6, u_s6, v_s6;

	assign sat_tx = cpd_pkg::sat32(72'(m_a_s5 >>> 24) + 72'(m_b_s5 >>> 24));
	assign sat_ty = cpd_pkg::sat32(72'(m_c_s5 >>> 24) + 72'(m_d_s5 >>> 24));

	always_ff @(posedge clk) begin
		if (en[5]) begin
			m_r3_s6  <= r2_s5 * r_s5;
			m_k2_s6  <= coef.k2 * r2_s5;
			fk1_s6   <= 48'(m_k1_s5 >>> 16);
			tx_s6    <= sat_tx.val;
			ty_s6    <= sat_ty.val;
			u_s6     <= u_s5;
			v_s6     <= v_s5;
			ovf_s[6] <= ovf_s[5] | sat_tx.ov | sat_ty.ov;
		end
	end

	// Stage 7: r^3 and partial radial sum
	cpd_pkg::sat_t      sat_r3;
	logic signed [48:0] fk12_s7;
	logic signed [31:0] r3_s7, tx_s7, ty_s7, u_s7, v_s7;

	assign sat_r3 = cpd_pkg::sat32(72'(m_r3_s6 >>> 16));

	always_ff @(posedge clk) begin
		if (en[6]) begin
			r3_s7    <= sat_r3.val;
			fk12_s7  <= 49'(fk1_s6) + 49'(m_k2_s6 >>> 16);
			tx_s7    <= tx_s6;
			ty_s7    <= ty_s6;
			u_s7     <= u_s6;
			v_s7     <= v_s6;
			ovf_s[7] <= ovf_s[6] | sat_r3.ov;
		end
	end

	// Stage 8: k3 product
	logic signed [63:0] m_k3_s8;
	logic signed [48:0] fk12_s8;
	logic signed [31:0] tx_s8, ty_s8, u_s8, v_s8;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			m_k3_s8  <= coef.k3 * r3_s7;
			fk12_s8  <= fk12_s7;
			tx_s8    <= tx_s7;
			ty_s8    <= ty_s7;
			u_s8     <= u_s7;
			v_s8     <= v_s7;
			ovf_s[8] <= ovf_s[7];
		end
	end

	// Stage 9: radial factor
	cpd_pkg::sat_t      sat_d;
	logic signed [31:0] d_s9, tx_s9, ty_s9, u_s9, v_s9;

	assign sat_d = cpd_pkg::sat32(72'(cpd_pkg::ONE_Q24) + 72'(fk12_s8)
		+ 72'(m_k3_s8 >>> 16));

	always_ff @(posedge clk) begin
		if (en[8]) begin
			d_s9     <= sat_d.val;
			tx_s9    <= tx_s8;
			ty_s9    <= ty_s8;
			u_s9     <= u_s8;
			v_s9     <= v_s8;
			ovf_s[9] <= ovf_s[8] | sat_d.ov;
		end
	end

	// Stage 10: scale coordinates by the radial factor
	logic signed [63:0] m_du_s10, m_dv_s10;
	logic signed [31:0] tx_s10, ty_s10;

	always_ff @(posedge clk) begin
		if (en[9]) begin
			m_du_s10  <= d_s9 * u_s9;
			m_dv_s10  <= d_s9 * v_s9;
			tx_s10    <= tx_s9;
			ty_s10    <= ty_s9;
			ovf_s[10] <= ovf_s[9];
		end
	end

	// Stage 11: distorted coordinates
	cpd_pkg::sat_t      sat_dx, sat_dy;
	logic signed [31:0] dx_s11, dy_s11;

	assign sat_dx = cpd_pkg::sat32(72'(m_du_s10 >>> 24) + 72'(tx_s10));
	assign sat_dy = cpd_pkg::sat32(72'(m_dv_s10 >>> 24) + 72'(ty_s10));

	always_ff @(posedge clk) begin
		if (en[10]) begin
			dx_s11    <= sat_dx.val;
			dy_s11    <= sat_dy.val;
			ovf_s[11] <= ovf_s[10] | sat_dx.ov | sat_dy.ov;
		end
	end

	// Stage 12: focal scaling
	logic signed [64:0] m_pu_s12, m_pv_s12;

	always_ff @(posedge clk) begin
		if (en[11]) begin
			m_pu_s12  <= signed'({1'b0, coef.focal_x}) * dx_s11;
			m_pv_s12  <= signed'({1'b0, coef.focal_y}) * dy_s11;
			ovf_s[12] <= ovf_s[11];
		end
	end

	// Stage 13: center offset into the output word, zero depth forces zeros
	cpd_pkg::sat_t sat_pu, sat_pv;

	assign sat_pu = cpd_pkg::sat32(72'(m_pu_s12 >>> 16) + 72'(coef.center_x));
	assign sat_pv = cpd_pkg::sat32(72'(m_pv_s12 >>> 16) + 72'(coef.center_y));

	always_ff @(posedge clk) begin
		if (en[12]) begin
			pixel_u    <= zf_s[12] ? 32'sd0 : sat_pu.val;
			pixel_v    <= zf_s[12] ? 32'sd0 : sat_pv.val;
			zero_depth <= zf_s[12];
			overflowed <= ~zf_s[12] & (ovf_s[12] | sat_pu.ov | sat_pv.ov);
		end
	end

endmodule

`default_nettype wire

[rtl/cpd_checker.sv]
// Port-level checker for the camera projection block, bound to the top
// level. Depends on camera_project_with_distortion_assert.svh.
`default_nettype none

`include "camera_project_with_distortion_assert.svh"

module cpd_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               point_stall,
	input wire logic               pixel_valid,
	input wire logic               pixel_stall,
	input wire logic signed [31:0] pixel_u,
	input wire logic signed [31:0] pixel_v,
	input wire logic               zero_depth,
	input wire logic               overflowed
);

	// A zero-depth word carries zero pixels and no overflow
	`CPD_ASSERT_NOW(a_zero_depth, !(pixel_valid && zero_depth) || (pixel_u == 32'sd0 && pixel_v == 32'sd0 && !overflowed), "zero depth word not cleared")

	// A free output stage never back-pressures the point channel
	`CPD_ASSERT_NOW(a_no_false_stall, !(!pixel_valid || !pixel_stall) || !point_stall, "point stalled while output can move")

	// A stalled pixel word holds
	`CPD_ASSERT_NEXT(a_hold, pixel_valid && pixel_stall, pixel_valid && $stable(pixel_u) && $stable(pixel_v), "stalled pixel word changed")

endmodule

bind camera_project_with_distortion cpd_checker u_cpd_checker (.*);

`default_nettype wire
